FILE: rtl/core/ljpa_pkg.sv
// Shared constants, minimum-image and saturation helpers for the Lennard-Jones pair accumulator.
`timescale 1ns / 1ps
`default_nettype none
package ljpa_pkg;
  localparam int COORD_W = 24;
  localparam int IDX_W   = 12;
  localparam int EXCL_W  = 13;
  localparam int ACC_W   = 48;
  localparam int SQ_W    = 48;
  localparam int WORD_W  = 64;
  localparam int QUO_W   = 37;
  localparam int FRAC_W  = 33;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF  = 3'd5;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Magnitude of the minimum-image difference p - o, wrapped at most once.
  function automatic logic [COORD_W-1:0] min_mag(input logic [COORD_W-1:0] p,
                                                  input logic [COORD_W-1:0] o,
                                                  input logic [COORD_W-1:0] box);
    logic signed [COORD_W+2:0] d;
    logic signed [COORD_W+2:0] b;
    logic signed [COORD_W+2:0] w;
    logic [COORD_W+2:0] m;
    d = $signed({3'b000, p}) - $signed({3'b000, o});
    b = $signed({3'b000, box});
    if ((d <<< 1) >= b) begin
      w = d - b;
    end else if ((d <<< 1) <= -b) begin
      w = d + b;
    end else begin
      w = d;
    end
    m = w[COORD_W+2] ? 27'(-w) : 27'(w);
    return m[COORD_W-1:0];
  endfunction

  // Signed term from a magnitude, clamped to the accumulator range; top bit flags a clamp.
  function automatic logic [ACC_W:0] clamp_term(input logic neg,
                                                 input logic [WORD_W-1:0] mag);
    logic [WORD_W-1:0] neg_mag;
    neg_mag = -mag;
    if (neg) begin
      if (mag > {16'd0, ACC_MIN}) begin
        return {1'b1, ACC_MIN};
      end
      return {1'b0, neg_mag[ACC_W-1:0]};
    end
    if (mag > {16'd0, ACC_MAX}) begin
      return {1'b1, ACC_MAX};
    end
    return {1'b0, mag[ACC_W-1:0]};
  endfunction

  // Saturating signed add; top bit flags saturation.
  function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] a,
                                              input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return {1'b1, s[ACC_W] ? ACC_MIN : ACC_MAX};
    end
    return {1'b0, s[ACC_W-1:0]};
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/ljpa_mul.sv
// Four-step fixed-point multiplier computing floor(a*b/2^32) with one 32x32 multiplier.
`timescale 1ns / 1ps
`default_nettype none
module ljpa_mul import ljpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] a,
  input  wire logic [WORD_W-1:0] b,
  output logic                   busy,
  output logic                   done,
  output logic [WORD_W-1:0]      prod
);
  logic [WORD_W-1:0] a_q;
  logic [WORD_W-1:0] b_q;
  logic [1:0] step;
  logic [31:0] x;
  logic [31:0] y;
  logic [WORD_W-1:0] pp;
  logic [WORD_W-1:0] term;
  logic [WORD_W-1:0] prod_next;

  always_comb begin
    unique case (step)
      2'd0: begin
        x = a_q[31:0];
        y = b_q[31:0];
      end
      2'd1: begin
        x = a_q[63:32];
        y = b_q[31:0];
      end
      2'd2: begin
        x = a_q[31:0];
        y = b_q[63:32];
      end
      default: begin
        x = a_q[63:32];
        y = b_q[63:32];
      end
    endcase
    pp = 64'(x) * 64'(y);
    unique case (step)
      2'd0: term = {32'd0, pp[63:32]};
      2'd3: term = {pp[31:0], 32'd0};
      default: term = pp;
    endcase
    prod_next = ((step == 2'd0) ? 64'd0 : prod) + term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
    end
    if (busy) begin
      prod <= prod_next;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/ljpa_div.sv
// Restoring divider computing floor(num*2^32/den) one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ljpa_div import ljpa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SQ_W-1:0]  num,
  input  wire logic [SQ_W-1:0]  den,
  output logic                  busy,
  output logic                  done,
  output logic [QUO_W-1:0]      quo
);
  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] den_q;
  logic [QUO_W-1:0] bits;
  logic [5:0] cnt;
  logic [SQ_W:0] t;
  logic ge;

  always_comb begin
    t = {rem, bits[QUO_W-1]};
    ge = t >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {5'd0, num[SQ_W-1:5]};
      bits  <= {num[4:0], 32'd0};
      den_q <= den;
    end else if (busy) begin
      rem  <= ge ? 48'(t - {1'b0, den_q}) : t[SQ_W-1:0];
      bits <= {bits[QUO_W-2:0], 1'b0};
      quo  <= {quo[QUO_W-2:0], ge};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/lennard_jones_pair_accumulator_unit.sv
// Top level of the Lennard-Jones 12-6 pair accumulator with cutoff and minimum image.
`timescale 1ns / 1ps
`default_nettype none
// Each beat on the input channel is one atom pair. A small sequencer handles one pair at a
// time and drives a four-step 32x32 multiplier and a one-bit-per-cycle divider. After a
// beat is taken the input is not ready until that pair is done: through five squarings if
// the atom is excluded, outside the cutoff or too close, and through four divisions and
// thirteen products if it is inside the cutoff. The sums leave on the output channel
// after a beat marked last and are then cleared. A new atom is taken while that result
// waits, but a further atom marked last holds in its final step until the waiting result
// has been taken.
module lennard_jones_pair_accumulator_unit import ljpa_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [COORD_W-1:0]       cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [COORD_W-1:0]       other_x,
  input  wire logic [COORD_W-1:0]       other_y,
  input  wire logic [COORD_W-1:0]       other_z,
  input  wire logic [IDX_W-1:0]         other_index,
  input  wire logic [COORD_W-1:0]       probe_x,
  input  wire logic [COORD_W-1:0]       probe_y,
  input  wire logic [COORD_W-1:0]       probe_z,
  input  wire logic signed [EXCL_W-1:0] excluded_index,
  input  wire logic                     last,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [ACC_W-1:0]       energy_sum,
  output logic signed [ACC_W-1:0]       stress_xx,
  output logic signed [ACC_W-1:0]       stress_yy,
  output logic signed [ACC_W-1:0]       stress_zz,
  output logic                          saturated
);
  localparam logic [4:0] P_IDLE = 5'd0;
  localparam logic [4:0] P_SQX  = 5'd1;
  localparam logic [4:0] P_SQY  = 5'd2;
  localparam logic [4:0] P_SQZ  = 5'd3;
  localparam logic [4:0] P_CUT  = 5'd4;
  localparam logic [4:0] P_SIG  = 5'd5;
  localparam logic [4:0] P_TEST = 5'd6;
  localparam logic [4:0] P_S2   = 5'd7;
  localparam logic [4:0] P_S4   = 5'd8;
  localparam logic [4:0] P_S6   = 5'd9;
  localparam logic [4:0] P_S12  = 5'd10;
  localparam logic [4:0] P_EN   = 5'd11;
  localparam logic [4:0] P_VG   = 5'd12;
  localparam logic [4:0] P_FX   = 5'd13;
  localparam logic [4:0] P_VX   = 5'd14;
  localparam logic [4:0] P_FY   = 5'd15;
  localparam logic [4:0] P_VY   = 5'd16;
  localparam logic [4:0] P_FZ   = 5'd17;
  localparam logic [4:0] P_VZ   = 5'd18;
  localparam logic [4:0] P_ACC  = 5'd19;

  logic [COORD_W-1:0] box_x, box_y, box_z, sigma_len, well_depth, cutoff_len;
  logic [4:0] pc;
  logic launch;
  logic [COORD_W-1:0] dm [3];
  logic [2:0] dnz;
  logic skip, last_q;
  logic [SQ_W-1:0] d2 [3];
  logic [SQ_W-1:0] cut2, sg2;
  logic [SQ_W-1:0] r2;
  logic [QUO_W-1:0] s2;
  logic [FRAC_W-1:0] frac;
  logic [WORD_W-1:0] s4, s6, s12, g;
  logic [ACC_W-1:0] te;
  logic [ACC_W-1:0] tv [3];
  logic term_flag;
  logic [ACC_W-1:0] energy_acc, vx_acc, vy_acc, vz_acc;
  logic overflow_seen;

  logic mul_start, mul_busy, mul_done;
  logic [WORD_W-1:0] mul_a, mul_b, mul_p;
  logic div_start, div_busy, div_done;
  logic [SQ_W-1:0] div_num;
  logic [QUO_W-1:0] div_q;

  logic [SQ_W+1:0] r2_sum;
  logic eneg, vneg;
  logic [WORD_W-1:0] emag, wmag, w2;
  logic is_div;
  logic [ACC_W:0] sum_e, sum_x, sum_y, sum_z, clamped;
  logic acc_hold, ov_next;
  logic close_hit, emit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (pc == P_IDLE);

  always_comb begin
    r2_sum = 50'(d2[0]) + 50'(d2[1]) + 50'(d2[2]);
    eneg = s12 < s6;
    emag = eneg ? s6 - s12 : s12 - s6;
    w2   = {s12[62:0], 1'b0};
    vneg = w2 < s6;
    wmag = vneg ? s6 - w2 : w2 - s6;
    is_div = (pc == P_S2) || (pc == P_FX) || (pc == P_FY) || (pc == P_FZ);
    mul_a = 64'd0;
    mul_b = 64'd0;
    div_num = sg2;
    unique case (pc)
      P_SQX: begin
        mul_a = {8'd0, dm[0], 32'd0};
        mul_b = {40'd0, dm[0]};
      end
      P_SQY: begin
        mul_a = {8'd0, dm[1], 32'd0};
        mul_b = {40'd0, dm[1]};
      end
      P_SQZ: begin
        mul_a = {8'd0, dm[2], 32'd0};
        mul_b = {40'd0, dm[2]};
      end
      P_CUT: begin
        mul_a = {8'd0, cutoff_len, 32'd0};
        mul_b = {40'd0, cutoff_len};
      end
      P_SIG: begin
        mul_a = {8'd0, sigma_len, 32'd0};
        mul_b = {40'd0, sigma_len};
      end
      P_S4: begin
        mul_a = {27'd0, s2};
        mul_b = {27'd0, s2};
      end
      P_S6: begin
        mul_a = s4;
        mul_b = {27'd0, s2};
      end
      P_S12: begin
        mul_a = s6;
        mul_b = s6;
      end
      P_EN: begin
        mul_a = {40'd0, well_depth};
        mul_b = emag;
      end
      P_VG: begin
        mul_a = {40'd0, well_depth};
        mul_b = wmag;
      end
      P_VX, P_VY, P_VZ: begin
        mul_a = g;
        mul_b = {31'd0, frac};
      end
      P_FX: div_num = d2[0];
      P_FY: div_num = d2[1];
      P_FZ: div_num = d2[2];
      default: begin
      end
    endcase
    mul_start = launch && !is_div && (pc != P_IDLE) && (pc != P_TEST) && (pc != P_ACC);
    div_start = launch && is_div;
    clamped = clamp_term(vneg, mul_p);
    sum_e = sat_add(energy_acc, te);
    sum_x = sat_add(vx_acc, tv[0]);
    sum_y = sat_add(vy_acc, tv[1]);
    sum_z = sat_add(vz_acc, tv[2]);
    ov_next = overflow_seen | term_flag | sum_e[ACC_W] | sum_x[ACC_W] | sum_y[ACC_W]
              | sum_z[ACC_W];
    close_hit = !skip && (r2_sum < {2'b00, cut2})
                && (r2_sum == '0 || {7'd0, sg2} >= {r2_sum, 5'd0});
    acc_hold = last_q && out_valid && !out_ready;
    emit = (pc == P_ACC) && last_q && !acc_hold;
  end

  ljpa_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_p)
  );

  ljpa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (r2),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x      <= 24'd2097152;
      box_y      <= 24'd2097152;
      box_z      <= 24'd2097152;
      sigma_len  <= 24'd222822;
      well_depth <= 24'd30720;
      cutoff_len <= 24'd891290;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BOX_X:  box_x      <= cfg_data;
        CFG_BOX_Y:  box_y      <= cfg_data;
        CFG_BOX_Z:  box_z      <= cfg_data;
        CFG_SIGMA:  sigma_len  <= cfg_data;
        CFG_EPS:    well_depth <= cfg_data;
        CFG_CUTOFF: cutoff_len <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= P_IDLE;
      launch        <= 1'b0;
      out_valid     <= 1'b0;
      energy_acc    <= '0;
      vx_acc        <= '0;
      vy_acc        <= '0;
      vz_acc        <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (mul_start || div_start) begin
        launch <= 1'b0;
      end
      unique case (pc)
        P_IDLE: begin
          if (in_valid) begin
            pc     <= P_SQX;
            launch <= 1'b1;
          end
        end
        P_TEST: begin
          if (skip || !(r2_sum < {2'b00, cut2})) begin
            pc <= P_ACC;
          end else if (r2_sum == '0 || {7'd0, sg2} >= {r2_sum, 5'd0}) begin
            pc <= P_ACC;
          end else begin
            pc     <= P_S2;
            launch <= 1'b1;
          end
        end
        P_ACC: begin
          if (!acc_hold) begin
            pc <= P_IDLE;
            if (last_q) begin
              energy_sum    <= sum_e[ACC_W-1:0];
              stress_xx     <= sum_x[ACC_W-1:0];
              stress_yy     <= sum_y[ACC_W-1:0];
              stress_zz     <= sum_z[ACC_W-1:0];
              saturated     <= ov_next;
              energy_acc    <= '0;
              vx_acc        <= '0;
              vy_acc        <= '0;
              vz_acc        <= '0;
              overflow_seen <= 1'b0;
            end else begin
              energy_acc    <= sum_e[ACC_W-1:0];
              vx_acc        <= sum_x[ACC_W-1:0];
              vy_acc        <= sum_y[ACC_W-1:0];
              vz_acc        <= sum_z[ACC_W-1:0];
              overflow_seen <= ov_next;
            end
          end
        end
        P_VZ: begin
          if (mul_done) begin
            pc <= P_ACC;
          end
        end
        default: begin
          if (mul_done || div_done) begin
            pc     <= pc + 5'd1;
            launch <= (pc != P_SIG);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dm[0]  <= min_mag(probe_x, other_x, box_x);
      dm[1]  <= min_mag(probe_y, other_y, box_y);
      dm[2]  <= min_mag(probe_z, other_z, box_z);
      skip   <= !excluded_index[EXCL_W-1] && (excluded_index[IDX_W-1:0] == other_index);
      last_q <= last;
    end
    dnz <= {dm[2] != '0, dm[1] != '0, dm[0] != '0};
    if (mul_done) begin
      unique case (pc)
        P_SQX: d2[0] <= mul_p[SQ_W-1:0];
        P_SQY: d2[1] <= mul_p[SQ_W-1:0];
        P_SQZ: d2[2] <= mul_p[SQ_W-1:0];
        P_CUT: cut2 <= mul_p[SQ_W-1:0];
        P_SIG: sg2 <= mul_p[SQ_W-1:0];
        P_S4:  s4 <= mul_p;
        P_S6:  s6 <= mul_p;
        P_S12: s12 <= mul_p;
        P_EN: begin
          {term_flag, te} <= clamp_term(eneg, {mul_p[61:0], 2'b00});
        end
        P_VG:  g <= {mul_p[59:0], 4'd0} + {mul_p[60:0], 3'd0};
        P_VX: begin
          tv[0]     <= clamped[ACC_W-1:0];
          term_flag <= term_flag | clamped[ACC_W];
        end
        P_VY: begin
          tv[1]     <= clamped[ACC_W-1:0];
          term_flag <= term_flag | clamped[ACC_W];
        end
        P_VZ: begin
          tv[2]     <= clamped[ACC_W-1:0];
          term_flag <= term_flag | clamped[ACC_W];
        end
        default: begin
        end
      endcase
    end
    if (div_done) begin
      if (pc == P_S2) begin
        s2 <= div_q;
      end else begin
        frac <= div_q[FRAC_W-1:0];
      end
    end
    if (pc == P_TEST) begin
      r2        <= r2_sum[SQ_W-1:0];
      term_flag <= close_hit;
      if (close_hit) begin
        te    <= (well_depth != '0) ? ACC_MAX : '0;
        tv[0] <= (well_depth != '0 && dnz[0]) ? ACC_MAX : '0;
        tv[1] <= (well_depth != '0 && dnz[1]) ? ACC_MAX : '0;
        tv[2] <= (well_depth != '0 && dnz[2]) ? ACC_MAX : '0;
      end else begin
        te    <= '0;
        tv[0] <= '0;
        tv[1] <= '0;
        tv[2] <= '0;
      end
    end
  end

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_busy && div_busy))
    else $error("multiplier and divider busy together");

  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_result_from_acc: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pc == P_ACC) && $past(last_q))
    else $error("result raised outside the accumulate step");
endmodule
`default_nettype wire
